FILE: hdl/frsc_pkg.sv
// Shared types and constants of the first repeat sample counter.
`timescale 1ns / 1ps
`default_nettype none

package frsc_pkg;

  localparam int unsigned IdxW  = 16;
  localparam int unsigned PopW  = 17;
  localparam int unsigned RunsW = 16;
  localparam int unsigned DrawW = 17;
  localparam int unsigned SumW  = 32;
  localparam int unsigned CfgW  = 17;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_POPULATION = 2'd0;
  localparam cfg_idx_t CFG_RUNS       = 2'd1;

  localparam logic [PopW-1:0]  POP_RESET  = 17'd65536;
  localparam logic [RunsW-1:0] RUNS_RESET = 16'd1;

  localparam logic STATUS_REPEAT = 1'b0;
  localparam logic STATUS_RANGE  = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ADD_SAT,
    ALU_GE
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [SumW-1:0]   a;
    logic [SumW-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [SumW-1:0] res;
    logic            flag;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/first_repeat_sample_counter_unit.sv
// Top level of the first repeat sample counter: sequencer, bitmap, mark list and config.
// An out-of-range index ends with a result strobe, a fresh index keeps busy high and gives
// no result, and a repeat lasts as long as the clearing walk through the mark list RAM
// takes for the listed marks. Busy stays high until a request is done, so no new request
// is taken before then; every step uses the one adder.
// After reset the visited bitmap is cleared, one entry a cycle, with busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module first_repeat_sample_counter_unit #(
  parameter int unsigned MAX_POPULATION = 65536
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [frsc_pkg::IdxW-1:0]   sample_index_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire frsc_pkg::cfg_idx_t          cfg_index_i,
  input  wire logic [frsc_pkg::CfgW-1:0]   cfg_data_i,
  output logic                             result_valid_o,
  output logic                             status_o,
  output logic [frsc_pkg::DrawW-1:0]       draw_count_o,
  output logic [frsc_pkg::SumW-1:0]        batch_total_o,
  output logic                             batch_last_o
);
  import frsc_pkg::*;

  // Address width of both memories and width of the mark count, which can reach the depth.
  localparam int unsigned AddrW = $clog2(MAX_POPULATION);
  localparam int unsigned CntW  = $clog2(MAX_POPULATION + 1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_MARK  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_WALKW = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_RUNS  = 4'd8;
  localparam logic [3:0] S_LAST  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [IdxW-1:0]  ix_q, ix_d;
  logic [DrawW-1:0] draw_q, draw_d;
  logic [CntW-1:0]  mcount_q, mcount_d;
  logic [CntW-1:0]  walk_q, walk_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [RunsW-1:0] runs_q, runs_d;
  logic [PopW-1:0]  pop_q;
  logic [RunsW-1:0] rpb_q;

  logic             res_valid_d;
  logic             res_status_d;
  logic             res_last_d;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  logic             bm_we, bm_wdata, bm_re, bm_rdata;
  logic [AddrW-1:0] bm_waddr, bm_raddr;
  logic             ml_we, ml_re;
  logic [AddrW-1:0] ml_waddr, ml_raddr;
  logic [IdxW-1:0]  ml_rdata;

  logic             beyond_cap;
  logic [RunsW-1:0] rpb_eff;

  frsc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Visited bitmap: one bit per index of the population.
  frsc_ram #(
    .Depth (MAX_POPULATION),
    .Width (1)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // Mark list: the indices set in the bitmap during the current run, in order.
  frsc_ram #(
    .Depth (MAX_POPULATION),
    .Width (IdxW)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ml_we),
    .waddr_i (ml_waddr),
    .wdata_i (ix_q),
    .re_i    (ml_re),
    .raddr_i (ml_raddr),
    .rdata_o (ml_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Indices at or above the memory depth are out of range whatever the population says.
  assign beyond_cap = (32'(ix_q) >= 32'(MAX_POPULATION));
  // A batch size of zero behaves as a batch of one run.
  assign rpb_eff    = (rpb_q == '0) ? RUNS_RESET : rpb_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    ix_d         = ix_q;
    draw_d       = draw_q;
    mcount_d     = mcount_q;
    walk_d       = walk_q;
    sum_d        = sum_q;
    runs_d       = runs_q;
    res_valid_d  = 1'b0;
    res_status_d = STATUS_REPEAT;
    res_last_d   = 1'b0;

    alu_req.op   = ALU_ADD;
    alu_req.a    = '0;
    alu_req.b    = '0;

    bm_we        = 1'b0;
    bm_waddr     = AddrW'(ix_q);
    bm_wdata     = 1'b0;
    bm_re        = 1'b0;
    bm_raddr     = AddrW'(ix_q);
    ml_we        = 1'b0;
    ml_waddr     = mcount_q[AddrW-1:0];
    ml_re        = 1'b0;
    ml_raddr     = walk_q[AddrW-1:0];

    unique case (state_q)
      S_INIT: begin
        // Sweep the bitmap clear after reset.
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = 1'b0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AddrW'(MAX_POPULATION - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ix_d    = sample_index_i;
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        alu_req.op = ALU_GE;
        alu_req.a  = 32'(ix_q);
        alu_req.b  = 32'(pop_q);
        if (alu_rsp.flag || beyond_cap) begin
          // Out-of-range index: report the current run state and change nothing.
          res_valid_d  = 1'b1;
          res_status_d = STATUS_RANGE;
          state_d      = S_IDLE;
        end else begin
          bm_re   = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = 32'(draw_q);
        alu_req.b  = 32'd1;
        draw_d     = alu_rsp.res[DrawW-1:0];
        if (bm_rdata) begin
          walk_d  = '0;
          state_d = S_WALK;
        end else begin
          bm_we    = 1'b1;
          bm_wdata = 1'b1;
          ml_we    = (mcount_q != CntW'(MAX_POPULATION));
          state_d  = S_MARK;
        end
      end
      S_MARK: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = 32'(mcount_q);
        alu_req.b  = 32'd1;
        if (mcount_q != CntW'(MAX_POPULATION)) begin
          mcount_d = alu_rsp.res[CntW-1:0];
        end
        state_d = S_IDLE;
      end
      S_WALK: begin
        // Each listed mark is read back and its bitmap entry cleared.
        alu_req.op = ALU_GE;
        alu_req.a  = 32'(walk_q);
        alu_req.b  = 32'(mcount_q);
        if (alu_rsp.flag) begin
          state_d = S_SUM;
        end else begin
          ml_re   = 1'b1;
          state_d = S_WALKW;
        end
      end
      S_WALKW: begin
        bm_we      = 1'b1;
        bm_waddr   = AddrW'(ml_rdata);
        bm_wdata   = 1'b0;
        alu_req.op = ALU_ADD;
        alu_req.a  = 32'(walk_q);
        alu_req.b  = 32'd1;
        walk_d     = alu_rsp.res[CntW-1:0];
        state_d    = S_WALK;
      end
      S_SUM: begin
        mcount_d   = '0;
        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = sum_q;
        alu_req.b  = 32'(draw_q);
        sum_d      = alu_rsp.res;
        state_d    = S_RUNS;
      end
      S_RUNS: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = 32'(runs_q);
        alu_req.b  = 32'd1;
        runs_d     = alu_rsp.res[RunsW-1:0];
        state_d    = S_LAST;
      end
      S_LAST: begin
        // The batch completes when the run count reaches the batch size or wraps to zero.
        alu_req.op   = ALU_GE;
        alu_req.a    = 32'(runs_q);
        alu_req.b    = 32'(rpb_eff);
        res_valid_d  = 1'b1;
        res_status_d = STATUS_REPEAT;
        res_last_d   = alu_rsp.flag || (runs_q == '0);
        draw_d       = '0;
        if (res_last_d) begin
          sum_d  = '0;
          runs_d = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      clr_q          <= '0;
      draw_q         <= '0;
      mcount_q       <= '0;
      walk_q         <= '0;
      sum_q          <= '0;
      runs_q         <= '0;
      pop_q          <= POP_RESET;
      rpb_q          <= RUNS_RESET;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      draw_q         <= draw_d;
      mcount_q       <= mcount_d;
      walk_q         <= walk_d;
      sum_q          <= sum_d;
      runs_q         <= runs_d;
      result_valid_o <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_POPULATION: pop_q <= cfg_data_i[PopW-1:0];
          CFG_RUNS:       rpb_q <= cfg_data_i[RunsW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // The result payload is captured when the strobe is raised; the draw count and the
  // batch total are those held when the result is formed.
  always_ff @(posedge clk_i) begin
    ix_q <= ix_d;
    if (res_valid_d) begin
      status_o      <= res_status_d;
      draw_count_o  <= draw_q;
      batch_total_o <= sum_q;
      batch_last_o  <= res_last_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/frsc_alu.sv
// Shared adder of the sequencer: add, saturating add and unsigned compare.
`timescale 1ns / 1ps
`default_nettype none

module frsc_alu (
  input  wire frsc_pkg::alu_req_t req_i,
  output frsc_pkg::alu_rsp_t      rsp_o
);
  import frsc_pkg::*;

  logic [SumW-1:0] b_eff;
  logic            cin;
  logic [SumW:0]   sum;

  // A compare runs as a - b through the same adder; the carry out is a >= b.
  assign b_eff = (req_i.op == ALU_GE) ? ~req_i.b : req_i.b;
  assign cin   = (req_i.op == ALU_GE);
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} + {{SumW{1'b0}}, cin};

  always_comb begin
    rsp_o.flag = sum[SumW];
    case (req_i.op)
      ALU_ADD_SAT: rsp_o.res = sum[SumW] ? {SumW{1'b1}} : sum[SumW-1:0];
      default:     rsp_o.res = sum[SumW-1:0];
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/frsc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module frsc_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: bench/first_repeat_sample_counter_monitor.sv
// Passive checker for the first repeat sample counter: predicts each report and compares it.
`timescale 1ns / 1ps

module first_repeat_sample_counter_monitor #(
  parameter int unsigned MaxPop = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [frsc_pkg::IdxW-1:0]      sample_index_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  frsc_pkg::cfg_idx_t             cfg_index_i,
  input  logic [frsc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                           result_valid_i,
  input  logic                           status_i,
  input  logic [frsc_pkg::DrawW-1:0]     draw_count_i,
  input  logic [frsc_pkg::SumW-1:0]      batch_total_i,
  input  logic                           batch_last_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             reports_o,
  output int                             batch_ends_o
);

  typedef struct packed {
    logic                         status;
    logic [frsc_pkg::DrawW-1:0]   draws;
    logic [frsc_pkg::SumW-1:0]    total;
    logic                         last;
  } report_t;

  // Shadow of the block: visited bitmap, trail of marks in this run, counters and registers.
  bit                           seen [MaxPop];
  logic [frsc_pkg::IdxW-1:0]    mark_trail [$];
  logic [frsc_pkg::DrawW-1:0]   draw_tally;
  logic [frsc_pkg::SumW-1:0]    batch_acc;
  logic [frsc_pkg::RunsW-1:0]   runs_closed;
  logic [frsc_pkg::PopW-1:0]    pop_size;
  logic [frsc_pkg::RunsW-1:0]   runs_target;
  report_t                      awaited [$];
  int                           fails = 0;
  int                           reports = 0;
  int                           batch_ends = 0;

  task automatic clear_model();
    foreach (seen[i]) seen[i] = 1'b0;
    mark_trail.delete();
    awaited.delete();
    draw_tally  = '0;
    batch_acc   = '0;
    runs_closed = '0;
    pop_size    = frsc_pkg::POP_RESET;
    runs_target = frsc_pkg::RUNS_RESET;
  endtask

  // Advances the shadow by one accepted sample and queues the report it causes, if any.
  task automatic tally_sample(input logic [frsc_pkg::IdxW-1:0] idx);
    int unsigned                  span;
    logic [frsc_pkg::RunsW-1:0]   per_batch;
    logic [frsc_pkg::DrawW-1:0]   run_len;
    logic                         closes;
    report_t                      rep;
    span = (pop_size > MaxPop) ? MaxPop : pop_size;
    if (idx >= span) begin
      rep = '{status: frsc_pkg::STATUS_RANGE, draws: draw_tally, total: batch_acc, last: 1'b0};
      awaited.insert(awaited.size(), rep);
      return;
    end
    draw_tally = draw_tally + 1'b1;
    if (!seen[idx]) begin
      seen[idx] = 1'b1;
      mark_trail.insert(mark_trail.size(), idx);
      return;
    end
    run_len = draw_tally;
    foreach (mark_trail[k]) seen[mark_trail[k]] = 1'b0;
    mark_trail.delete();
    draw_tally = '0;
    if (batch_acc > 32'hFFFF_FFFF - 32'(run_len)) batch_acc = '1;
    else batch_acc = batch_acc + 32'(run_len);
    runs_closed = runs_closed + 1'b1;
    per_batch = (runs_target == '0) ? 16'd1 : runs_target;
    closes = (runs_closed >= per_batch) || (runs_closed == '0);
    rep = '{status: frsc_pkg::STATUS_REPEAT, draws: run_len, total: batch_acc, last: closes};
    awaited.insert(awaited.size(), rep);
    if (closes) begin
      batch_ends++;
      batch_acc   = '0;
      runs_closed = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_report();
    report_t want;
    if (awaited.size() == 0) begin
      fails++;
      $display("%0t: report with no request waiting, expected none, got status %0d draws %0d",
               $time, status_i, draw_count_i);
      return;
    end
    want = awaited.pop_front();
    reports++;
    check_field("status", 32'(want.status), 32'(status_i));
    check_field("draw_count", 32'(want.draws), 32'(draw_count_i));
    check_field("batch_total", want.total, batch_total_i);
    check_field("batch_last", 32'(want.last), 32'(batch_last_i));
  endtask

  // Reports are compared before a new request is predicted: a report seen at the same edge
  // as an accepted request always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (result_valid_i) compare_report();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          frsc_pkg::CFG_POPULATION: pop_size = cfg_data_i[frsc_pkg::PopW-1:0];
          frsc_pkg::CFG_RUNS:       runs_target = cfg_data_i[frsc_pkg::RunsW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) tally_sample(sample_index_i);
    end
    fail_count_o <= fails;
    pending_o    <= awaited.size();
    reports_o    <= reports;
    batch_ends_o <= batch_ends;
  end

endmodule

FILE: bench/first_repeat_sample_counter_unit_test.sv
// Testbench top for the first repeat sample counter: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module first_repeat_sample_counter_unit_test;

  localparam int unsigned MaxPop = 65536;
  // The longest quiet stretch of a correct run is the clearing walk after a repeat with a
  // full mark list; the bitmap clear after reset is shorter.
  localparam int StallLimit   = 400000;
  localparam int QuietCycles  = 8;
  localparam int TailCycles   = 20;
  localparam int RandomItems  = 450;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [frsc_pkg::IdxW-1:0]      sample_index_i;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  frsc_pkg::cfg_idx_t             cfg_index_i;
  logic [frsc_pkg::CfgW-1:0]      cfg_data_i;
  logic                           result_valid_o;
  logic                           status_o;
  logic [frsc_pkg::DrawW-1:0]     draw_count_o;
  logic [frsc_pkg::SumW-1:0]      batch_total_o;
  logic                           batch_last_o;

  int fail_count;
  int pending;
  int reports;
  int batch_ends;

  // Stimulus bookkeeping: current idle rate of the sender, the population last written
  // (to aim draws inside it) and a short history of drawn indices to force repeats.
  int                             idle_pct;
  int                             samples_sent;
  int                             phases_run;
  int                             stall_count;
  logic [frsc_pkg::PopW-1:0]      pop_now;
  logic [frsc_pkg::IdxW-1:0]      recent [$];

  first_repeat_sample_counter_unit #(
    .MAX_POPULATION(MaxPop)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_index_i (sample_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .draw_count_o   (draw_count_o),
    .batch_total_o  (batch_total_o),
    .batch_last_o   (batch_last_o)
  );

  first_repeat_sample_counter_monitor #(
    .MaxPop(MaxPop)
  ) u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .sample_index_i (sample_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .draw_count_i   (draw_count_o),
    .batch_total_i  (batch_total_o),
    .batch_last_i   (batch_last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .reports_o      (reports),
    .batch_ends_o   (batch_ends)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: any request, report or register write counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_count = 0;
    end else begin
      stall_count = stall_count + 1;
      if (stall_count >= StallLimit) begin
        $display("Timeout after %0d cycles without progress, %0d reports outstanding",
                 stall_count, pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Sends one sample request. Before it, the sender may idle for a random number of
  // cycles; with no idling, start simply stays high and the next index follows at once,
  // so requests also wait out every busy phase of the block.
  task automatic issue_sample(input logic [frsc_pkg::IdxW-1:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    sample_index_i <= idx;
    do @(posedge clk_i); while (busy);
    samples_sent++;
    recent.insert(recent.size(), idx);
    if (recent.size() > 64) void'(recent.pop_front());
  endtask

  // Waits until every predicted report has arrived, then lets a fresh sample (which
  // never reports) finish its own busy cycles before anything is reconfigured.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input frsc_pkg::cfg_idx_t idx, input logic [frsc_pkg::CfgW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == frsc_pkg::CFG_POPULATION) pop_now = data;
  endtask

  // The run count register is 16 bits wide; the unused top bit of the write data is
  // randomized, since the block must ignore it.
  task automatic set_phase(input logic [frsc_pkg::PopW-1:0] pop,
                           input logic [frsc_pkg::RunsW-1:0] runs);
    write_reg(frsc_pkg::CFG_POPULATION, pop);
    write_reg(frsc_pkg::CFG_RUNS, {1'($urandom_range(1, 0)), runs});
  endtask

  // Mostly small populations so that repeats, and with them run ends, come often;
  // full size, beyond capacity and empty populations appear now and then.
  function automatic logic [frsc_pkg::PopW-1:0] pick_population();
    case ($urandom_range(9, 0))
      0:       return 17'd1;
      1:       return 17'd2;
      2, 3:    return 17'($urandom_range(16, 3));
      4, 5:    return 17'($urandom_range(300, 17));
      6:       return 17'($urandom_range(8192, 301));
      7:       return frsc_pkg::POP_RESET;
      8:       return 17'($urandom_range(131071, 65537));
      default: return ($urandom_range(1, 0) == 0) ? 17'd0 : 17'($urandom_range(65535, 2));
    endcase
  endfunction

  function automatic logic [frsc_pkg::RunsW-1:0] pick_runs();
    case ($urandom_range(5, 0))
      0:       return 16'd0;
      1:       return 16'd1;
      2, 3:    return 16'($urandom_range(6, 2));
      4:       return 16'($urandom_range(40, 7));
      default: return 16'hFFFF;
    endcase
  endfunction

  // A draw is either a replay of a recent index (forces repeats even in large
  // populations), a uniform index inside the population, or a raw 16-bit value that
  // is often out of range.
  function automatic logic [frsc_pkg::IdxW-1:0] draw_index();
    int unsigned span;
    int          pick;
    span = (pop_now > MaxPop) ? MaxPop : pop_now;
    pick = $urandom_range(99, 0);
    if (span != 0 && pick < 10 && recent.size() != 0)
      return recent[$urandom_range(recent.size() - 1, 0)];
    if (span != 0 && pick < 85)
      return 16'($urandom_range(span - 1, 0));
    return 16'($urandom);
  endfunction

  // Sender idle rate per random phase: none, three quarters, none, about a third.
  function automatic int idle_for(input int phase);
    case (phase % 4)
      1:       return 75;
      3:       return 36;
      default: return 0;
    endcase
  endfunction

  initial begin
    int burst;
    int target;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    sample_index_i <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= frsc_pkg::CFG_POPULATION;
    cfg_data_i     <= '0;
    idle_pct       = 0;
    samples_sent   = 0;
    phases_run     = 0;
    stall_count    = 0;
    pop_now        = frsc_pkg::POP_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: both ends of the index range are fresh, then zero repeats and
    // ends a one-run batch.
    issue_sample(16'd0);
    issue_sample(16'hFFFF);
    issue_sample(16'd0);

    // Four indices with zero runs per batch (acts as one): out-of-range before and
    // after filling the whole population, then the repeat that ends the run.
    set_phase(17'd4, 16'd0);
    issue_sample(16'd4);
    issue_sample(16'd0);
    issue_sample(16'd1);
    issue_sample(16'd2);
    issue_sample(16'd3);
    issue_sample(16'd5);
    issue_sample(16'hFFFF);
    issue_sample(16'd3);

    // An empty population rejects every index.
    write_reg(frsc_pkg::CFG_POPULATION, 17'd0);
    issue_sample(16'd0);
    issue_sample(16'hFFFF);

    // A population beyond capacity acts as full size. One run of a three-run batch
    // ends, and the next one leaves a mark at a high index.
    write_reg(frsc_pkg::CFG_POPULATION, 17'h1FFFF);
    write_reg(frsc_pkg::CFG_RUNS, 17'd3);
    issue_sample(16'd40000);
    issue_sample(16'd40000);
    issue_sample(16'd40001);

    // Mid-run the population shrinks below that mark and the batch shrinks to the runs
    // already done: the mark is now out of range, and the next repeat must both
    // complete the batch and still clear the stale mark.
    write_reg(frsc_pkg::CFG_POPULATION, 17'd10);
    write_reg(frsc_pkg::CFG_RUNS, 17'd1);
    issue_sample(16'd40001);
    issue_sample(16'd5);
    issue_sample(16'd5);

    // Back at full size the old mark must read as fresh again.
    write_reg(frsc_pkg::CFG_POPULATION, frsc_pkg::POP_RESET);
    issue_sample(16'd40001);
    issue_sample(16'd40001);

    // Random phases, each with its own registers and sender idle rate.
    target = samples_sent + RandomItems;
    while (samples_sent < target) begin
      idle_pct = idle_for(phases_run);
      set_phase(pick_population(), pick_runs());
      burst = $urandom_range(50, 20);
      repeat (burst) issue_sample(draw_index());
      phases_run++;
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d samples in %0d random phases plus directed cases", samples_sent,
             phases_run);
    $display("Checked %0d reports, %0d of which closed a batch", reports, batch_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
